/* hdl/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and codes for the string literal escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam logic [2:0] ST_BYTE     = 3'd0;
    localparam logic [2:0] ST_CONSUMED = 3'd1;
    localparam logic [2:0] ST_CLOSED   = 3'd2;
    localparam logic [2:0] ST_EOF      = 3'd3;
    localparam logic [2:0] ST_NEWLINE  = 3'd4;
    localparam logic [2:0] ST_BADESC   = 3'd5;
    localparam logic [2:0] ST_BADHEX   = 3'd6;
    localparam logic [2:0] ST_BADCHAR  = 3'd7;

    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_APOS     = 8'h27;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_LC_N     = 8'h6E;
    localparam logic [7:0] CH_LC_R     = 8'h72;
    localparam logic [7:0] CH_LC_T     = 8'h74;
    localparam logic [7:0] CH_LC_X     = 8'h78;
    localparam logic [7:0] CH_DIG_0    = 8'h30;
    localparam logic [7:0] CH_DIG_9    = 8'h39;
    localparam logic [7:0] CH_UC_A     = 8'h41;
    localparam logic [7:0] CH_UC_F     = 8'h46;
    localparam logic [3:0] HEX_A_VAL   = 4'd10;

    typedef enum logic [4:0] {
        MODE_START = 5'b00001,
        MODE_BODY  = 5'b00010,
        MODE_ESC   = 5'b00100,
        MODE_HEX1  = 5'b01000,
        MODE_HEX2  = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
        logic       double_quoted;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        mode_t      mode_next;
        logic [3:0] nibble_next;
        logic       quote_next;
    } dec_result_t;

endpackage

/* hdl/sed_in_stage.sv */
// ----------------------------------------------------------------------------
// sed_in_stage
// Input register: captures one transaction and holds it until it advances.
// ----------------------------------------------------------------------------
module sed_in_stage
    import sed_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* hdl/sed_decode.sv */
// ----------------------------------------------------------------------------
// sed_decode
// Decode one character against the current mode: result and next state.
// ----------------------------------------------------------------------------
module sed_decode
    import sed_pkg::*;
(
    input  in_item_t    item,
    input  mode_t       mode,
    input  logic [3:0]  nibble,
    input  logic        quote_dbl,
    output dec_result_t res
);

    logic [7:0] rd;
    logic       char_ok;
    logic       is_hex;
    logic [3:0] hex_nib;
    logic       quote_sel;
    logic [7:0] quote_ch;

    assign rd = item.end_of_input ? CH_NUL : item.ch;

    always_comb
    begin
        char_ok = ((rd >= CH_PRINT_LO) && (rd <= CH_PRINT_HI))
                  || (rd == CH_LF) || (rd == CH_TAB) || (rd == CH_CR);
        is_hex  = 1'b0;
        hex_nib = 4'd0;
        if ((rd >= CH_DIG_0) && (rd <= CH_DIG_9))
        begin
            is_hex  = 1'b1;
            hex_nib = 4'(rd - CH_DIG_0);
        end
        else if ((rd >= CH_UC_A) && (rd <= CH_UC_F))
        begin
            is_hex  = 1'b1;
            hex_nib = 4'(rd - CH_UC_A) + HEX_A_VAL;
        end
    end

    assign quote_sel = (mode == MODE_BODY) ? quote_dbl : item.double_quoted;
    assign quote_ch  = quote_sel ? CH_DQUOTE : CH_APOS;

    always_comb
    begin
        res.out_byte    = 8'd0;
        res.status      = ST_CONSUMED;
        res.mode_next   = mode;
        res.nibble_next = nibble;
        res.quote_next  = quote_dbl;
        case (mode)
            MODE_ESC:
            begin
                res.mode_next = MODE_BODY;
                res.status    = ST_BYTE;
                if (!char_ok)
                begin
                    res.status = ST_BADCHAR;
                end
                else
                begin
                    case (rd)
                        CH_LC_N:   res.out_byte = CH_LF;
                        CH_LC_R:   res.out_byte = CH_CR;
                        CH_LC_T:   res.out_byte = CH_TAB;
                        CH_DIG_0:  res.out_byte = CH_NUL;
                        CH_APOS:   res.out_byte = CH_APOS;
                        CH_DQUOTE: res.out_byte = CH_DQUOTE;
                        CH_BSLASH: res.out_byte = CH_BSLASH;
                        CH_LC_X:
                        begin
                            res.status    = ST_CONSUMED;
                            res.mode_next = MODE_HEX1;
                        end
                        default:   res.status = ST_BADESC;
                    endcase
                end
            end
            MODE_HEX1, MODE_HEX2:
            begin
                if (!char_ok)
                begin
                    res.status = ST_BADCHAR;
                end
                else if (!is_hex)
                begin
                    res.status = ST_BADHEX;
                end
                else if (mode == MODE_HEX1)
                begin
                    res.nibble_next = hex_nib;
                    res.mode_next   = MODE_HEX2;
                    res.status      = ST_CONSUMED;
                end
                else
                begin
                    res.out_byte  = {nibble, hex_nib};
                    res.status    = ST_BYTE;
                    res.mode_next = MODE_BODY;
                end
            end
            default:
            begin
                res.quote_next = quote_sel;
                res.mode_next  = MODE_BODY;
                if (rd == CH_NUL)
                begin
                    res.status = ST_EOF;
                end
                else if (!char_ok)
                begin
                    res.status = ST_BADCHAR;
                end
                else if (rd == quote_ch)
                begin
                    res.status = ST_CLOSED;
                end
                else if ((rd == CH_LF) || (rd == CH_CR))
                begin
                    res.status = ST_NEWLINE;
                end
                else if (rd == CH_BSLASH)
                begin
                    res.status    = ST_CONSUMED;
                    res.mode_next = MODE_ESC;
                end
                else
                begin
                    res.status   = ST_BYTE;
                    res.out_byte = rd;
                end
            end
        endcase
        if (res.status >= ST_CLOSED)
        begin
            res.mode_next = MODE_START;
        end
    end

endmodule

/* hdl/string_literal_escape_decoder.sv */
// A transaction is captured in the input register and moves on to the result
// register when that register is empty or being drained.
// Throughput: one character per cycle while the output is not stalled; the mode,
// nibble and quote registers update in the same cycle the character moves from
// the input register to the result register.
// Reset: asynchronous, active low; clears both valid flags and returns the
// mode to the start of a new literal with nibble and quote kind zero.
// ----------------------------------------------------------------------------
// string_literal_escape_decoder
// Decodes the characters of a quoted literal into bytes, closes and errors.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       end_of_input,
    input  logic       double_quoted,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [2:0] status
);

    in_item_t    in_item;
    in_item_t    item;
    logic        item_valid;
    logic        advance;
    dec_result_t res;

    mode_t       mode_reg;
    logic [3:0]  nibble_reg;
    logic        quote_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [2:0]  status_reg;

    assign in_item.ch            = ch;
    assign in_item.end_of_input  = end_of_input;
    assign in_item.double_quoted = double_quoted;

    assign advance = item_valid && (!out_valid_reg || !out_stall);

    sed_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sed_decode u_decode (
        .item      (item),
        .mode      (mode_reg),
        .nibble    (nibble_reg),
        .quote_dbl (quote_reg),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_START;
            nibble_reg    <= 4'd0;
            quote_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg   <= res.mode_next;
                nibble_reg <= res.nibble_next;
                quote_reg  <= res.quote_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= res.out_byte;
            status_reg   <= res.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;

endmodule

/* hdl/sed_checker.sv */
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks for the string literal escape decoder.
// ----------------------------------------------------------------------------
module sed_checker
    import sed_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic [2:0] status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status))
        else $error("stalled result transaction changed");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_BYTE) |-> out_byte == 8'd0)
        else $error("non-byte result carries a nonzero byte");

    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while result register is empty");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && !out_stall ##1 !in_valid && !out_stall |=> !out_valid)
        else $error("result appeared with no transaction in flight");

endmodule

bind string_literal_escape_decoder sed_checker u_sed_checker (.*);
